>>> design/glfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glfm_pkg
// Shared types and constants of the gated LFM chirp generator.
// ----------------------------------------------------------------------------
package glfm_pkg;

    // Bus and register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_PHASE_STEP   = 3'd0,
        REG_CHIRP_COEF   = 3'd1,
        REG_START_PHASE  = 3'd2,
        REG_AMPLITUDE    = 3'd3,
        REG_NOISE_GAIN   = 3'd4,
        REG_DELAY        = 3'd5,
        REG_WINDOW_LEN   = 3'd6
    } t_reg_idx;

    // Phase truncation and CORDIC sizing
    localparam int PHASE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_IDX_W   = $clog2(CORDIC_STAGES);
    localparam int XW            = 34;   // CORDIC x/y width, covers gain growth
    localparam int ZW            = 32;   // residual angle, 2^32 per turn
    localparam int NW            = 20;   // scaled noise term width
    localparam int MW            = 18;   // delayed time width

    // 1/K in Q16
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

    // Reset values
    localparam logic [14:0] AMPLITUDE_RESET = 15'd16384;
    localparam logic [15:0] WINDOW_RESET    = 16'd1024;
    localparam logic [30:0] X0_RESET        = 31'd652034048;  // 16384 * 39797

    // Quadrant of the folded phase
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // Live configuration, plus the precomputed CORDIC start magnitude
    typedef struct packed {
        logic        [31:0] phase_step;
        logic        [31:0] chirp_coef;
        logic        [15:0] start_phase;
        logic        [14:0] amplitude;
        logic        [14:0] noise_gain;
        logic signed [16:0] delay;
        logic        [15:0] window_len;
        logic        [30:0] x0;
    } t_cfg;

    // Per-item sideband that rides along the rotation pipeline
    typedef struct packed {
        logic signed [MW-1:0] m;
        logic                 in_win;
        logic signed [NW-1:0] nre;
        logic signed [NW-1:0] nim;
        t_quad                quad;
    } t_side;

    // Rotation angles, 2^32 per turn
    function automatic logic [ZW-1:0] atan_turn(input logic [STAGE_IDX_W-1:0] idx);
        logic [ZW-1:0] v;
        case (idx)
            4'd0:    v = 32'h20000000;
            4'd1:    v = 32'h12E4051E;
            4'd2:    v = 32'h09FB385B;
            4'd3:    v = 32'h051111D4;
            4'd4:    v = 32'h028B0D43;
            4'd5:    v = 32'h0145D7E1;
            4'd6:    v = 32'h00A2F61E;
            4'd7:    v = 32'h00517C55;
            4'd8:    v = 32'h0028BE53;
            4'd9:    v = 32'h00145F2F;
            4'd10:   v = 32'h000A2F98;
            4'd11:   v = 32'h000517CC;
            4'd12:   v = 32'h00028BE6;
            4'd13:   v = 32'h000145F3;
            4'd14:   v = 32'h0000A2FA;
            4'd15:   v = 32'h0000517D;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/glfm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glfm_regs
// APB register file holding the chirp configuration.
// ----------------------------------------------------------------------------
module glfm_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [glfm_pkg::ADDR_W-1:0]   paddr,
    input  logic [glfm_pkg::DATA_W-1:0]   pwdata,
    output logic [glfm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output glfm_pkg::t_cfg                o_cfg
);

    logic        [31:0] r_phase_step;
    logic        [31:0] r_chirp_coef;
    logic        [15:0] r_start_phase;
    logic        [14:0] r_amplitude;
    logic        [14:0] r_noise_gain;
    logic signed [16:0] r_delay;
    logic        [15:0] r_window_len;
    logic        [30:0] r_x0;

    glfm_pkg::t_reg_idx w_idx;
    logic               w_wr;
    logic        [30:0] n_x0;

    assign w_idx  = glfm_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= '0;
            r_chirp_coef  <= '0;
            r_start_phase <= '0;
            r_amplitude   <= glfm_pkg::AMPLITUDE_RESET;
            r_noise_gain  <= '0;
            r_delay       <= '0;
            r_window_len  <= glfm_pkg::WINDOW_RESET;
        end else if (w_wr) begin
            case (w_idx)
                glfm_pkg::REG_PHASE_STEP:  r_phase_step  <= pwdata;
                glfm_pkg::REG_CHIRP_COEF:  r_chirp_coef  <= pwdata;
                glfm_pkg::REG_START_PHASE: r_start_phase <= pwdata[15:0];
                glfm_pkg::REG_AMPLITUDE:   r_amplitude   <= pwdata[14:0];
                glfm_pkg::REG_NOISE_GAIN:  r_noise_gain  <= pwdata[14:0];
                glfm_pkg::REG_DELAY:       r_delay       <= $signed(pwdata[16:0]);
                glfm_pkg::REG_WINDOW_LEN:  r_window_len  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Gain-compensated CORDIC start magnitude, follows amplitude
    assign n_x0 = 31'(r_amplitude) * 31'(glfm_pkg::INV_GAIN_Q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0 <= glfm_pkg::X0_RESET;
        end else begin
            r_x0 <= n_x0;
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            glfm_pkg::REG_PHASE_STEP:  prdata = r_phase_step;
            glfm_pkg::REG_CHIRP_COEF:  prdata = r_chirp_coef;
            glfm_pkg::REG_START_PHASE: prdata = {16'd0, r_start_phase};
            glfm_pkg::REG_AMPLITUDE:   prdata = {17'd0, r_amplitude};
            glfm_pkg::REG_NOISE_GAIN:  prdata = {17'd0, r_noise_gain};
            glfm_pkg::REG_DELAY:       prdata = {15'd0, r_delay};
            glfm_pkg::REG_WINDOW_LEN:  prdata = {16'd0, r_window_len};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.phase_step  = r_phase_step;
    assign o_cfg.chirp_coef  = r_chirp_coef;
    assign o_cfg.start_phase = r_start_phase;
    assign o_cfg.amplitude   = r_amplitude;
    assign o_cfg.noise_gain  = r_noise_gain;
    assign o_cfg.delay       = r_delay;
    assign o_cfg.window_len  = r_window_len;
    assign o_cfg.x0          = r_x0;

endmodule

>>> design/glfm_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glfm_phase
// Five-stage front end: delayed time and gate, phase products, phase sum and
// quadrant fold, scaled noise terms.
// ----------------------------------------------------------------------------
module glfm_phase (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  glfm_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_acc,
    input  logic                 [15:0] i_sample_index,
    input  logic signed          [15:0] i_noise_re,
    input  logic signed          [15:0] i_noise_im,
    output logic                        o_valid,
    input  logic                        i_dn_acc,
    output logic signed [glfm_pkg::ZW-1:0] o_z,
    output glfm_pkg::t_side             o_side
);

    // Stage advance chain: a stage loads when empty or when it empties too
    logic w_acc1, w_acc2, w_acc3, w_acc4, w_acc5;

    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;

    // Stage 1
    logic signed [glfm_pkg::MW-1:0] r_s1_m;
    logic signed [15:0]             r_s1_nre, r_s1_nim;
    // Stage 2
    logic signed [glfm_pkg::MW-1:0] r_s2_m;
    logic                           r_s2_inside;
    logic        [15:0]             r_s2_ad;
    logic signed [31:0]             r_s2_pre, r_s2_pim;
    // Stage 3
    logic signed [glfm_pkg::MW-1:0] r_s3_m;
    logic                           r_s3_inside;
    logic        [31:0]             r_s3_ph1, r_s3_q;
    logic signed [glfm_pkg::NW-1:0] r_s3_nre, r_s3_nim;
    // Stage 4
    logic signed [glfm_pkg::MW-1:0] r_s4_m;
    logic                           r_s4_inside;
    logic        [31:0]             r_s4_ph1;
    logic        [39:0]             r_s4_chirp;
    logic signed [glfm_pkg::NW-1:0] r_s4_nre, r_s4_nim;
    // Stage 5
    logic signed [glfm_pkg::ZW-1:0] r_s5_z;
    glfm_pkg::t_side                r_s5_side;

    logic signed [glfm_pkg::MW-1:0] n_m;
    logic signed [18:0]             w_d;
    logic        [18:0]             w_dabs;
    logic                           n_inside;
    logic        [47:0]             w_ph1_full;
    logic        [31:0]             n_q;
    logic signed [31:0]             w_nre_r, w_nim_r;
    logic        [63:0]             w_chirp_full;
    logic        [31:0]             w_ph_sum;
    logic        [31:0]             w_ph;
    glfm_pkg::t_quad                n_quad;
    logic        [31:0]             w_res;

    assign w_acc5 = !r_s5_v || i_dn_acc;
    assign w_acc4 = !r_s4_v || w_acc5;
    assign w_acc3 = !r_s3_v || w_acc4;
    assign w_acc2 = !r_s2_v || w_acc3;
    assign w_acc1 = !r_s1_v || w_acc2;
    assign o_acc  = w_acc1;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            if (w_acc1) r_s1_v <= i_valid;
            if (w_acc2) r_s2_v <= r_s1_v;
            if (w_acc3) r_s3_v <= r_s2_v;
            if (w_acc4) r_s4_v <= r_s3_v;
            if (w_acc5) r_s5_v <= r_s4_v;
        end
    end

    // Stage 1: delayed time m = n + delay
    assign n_m = $signed({2'b00, i_sample_index}) +
                 $signed({i_cfg.delay[16], i_cfg.delay});

    always_ff @(posedge i_clk) begin
        if (w_acc1) begin
            r_s1_m   <= n_m;
            r_s1_nre <= i_noise_re;
            r_s1_nim <= i_noise_im;
        end
    end

    // Stage 2: window gate, |2m - L|, noise products
    assign n_inside = !r_s1_m[17] && (r_s1_m[16:0] <= {1'b0, i_cfg.window_len});
    assign w_d      = $signed({1'b0, r_s1_m[16:0], 1'b0}) -
                      $signed({3'b000, i_cfg.window_len});
    assign w_dabs   = w_d[18] ? 19'(-w_d) : 19'(w_d);

    always_ff @(posedge i_clk) begin
        if (w_acc2) begin
            r_s2_m      <= r_s1_m;
            r_s2_inside <= n_inside;
            r_s2_ad     <= w_dabs[15:0];
            r_s2_pre    <= 32'($signed({1'b0, i_cfg.noise_gain})) * 32'(r_s1_nre);
            r_s2_pim    <= 32'($signed({1'b0, i_cfg.noise_gain})) * 32'(r_s1_nim);
        end
    end

    // Stage 3: phase_step * m, (2m - L)^2, noise rounding
    assign w_ph1_full = 48'(i_cfg.phase_step) * 48'(r_s2_m[15:0]);
    assign n_q        = 32'(r_s2_ad) * 32'(r_s2_ad);
    assign w_nre_r    = (r_s2_pre + 32'sd1024) >>> 11;
    assign w_nim_r    = (r_s2_pim + 32'sd1024) >>> 11;

    always_ff @(posedge i_clk) begin
        if (w_acc3) begin
            r_s3_m      <= r_s2_m;
            r_s3_inside <= r_s2_inside;
            r_s3_ph1    <= w_ph1_full[31:0];
            r_s3_q      <= n_q;
            r_s3_nre    <= w_nre_r[glfm_pkg::NW-1:0];
            r_s3_nim    <= w_nim_r[glfm_pkg::NW-1:0];
        end
    end

    // Stage 4: chirp term, kept mod 2^40
    assign w_chirp_full = 64'(r_s3_q) * 64'(i_cfg.chirp_coef);

    always_ff @(posedge i_clk) begin
        if (w_acc4) begin
            r_s4_m      <= r_s3_m;
            r_s4_inside <= r_s3_inside;
            r_s4_ph1    <= r_s3_ph1;
            r_s4_chirp  <= w_chirp_full[39:0];
            r_s4_nre    <= r_s3_nre;
            r_s4_nim    <= r_s3_nim;
        end
    end

    // Stage 5: phase sum, truncation, quadrant fold
    assign w_ph_sum = r_s4_ph1 + r_s4_chirp[39:8] + {i_cfg.start_phase, 16'd0};
    assign w_ph     = {w_ph_sum[31 -: glfm_pkg::PHASE_BITS],
                       {(32 - glfm_pkg::PHASE_BITS){1'b0}}};
    assign n_quad   = glfm_pkg::t_quad'(w_ph[31:30] + {1'b0, w_ph[29]});
    assign w_res    = w_ph - {n_quad, 30'd0};

    always_ff @(posedge i_clk) begin
        if (w_acc5) begin
            r_s5_z           <= $signed(w_res);
            r_s5_side.m      <= r_s4_m;
            r_s5_side.in_win <= r_s4_inside;
            r_s5_side.nre    <= r_s4_nre;
            r_s5_side.nim    <= r_s4_nim;
            r_s5_side.quad   <= n_quad;
        end
    end

    assign o_valid = r_s5_v;
    assign o_z     = r_s5_z;
    assign o_side  = r_s5_side;

endmodule

>>> design/glfm_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glfm_cordic
// Rotation-mode CORDIC, one micro-rotation per pipeline stage.
// ----------------------------------------------------------------------------
module glfm_cordic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  glfm_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    output logic                           o_acc,
    input  logic signed [glfm_pkg::ZW-1:0] i_z,
    input  glfm_pkg::t_side                i_side,
    output logic                           o_valid,
    input  logic                           i_dn_acc,
    output logic signed [glfm_pkg::XW-1:0] o_x,
    output logic signed [glfm_pkg::XW-1:0] o_y,
    output glfm_pkg::t_side                o_side
);

    localparam int N = glfm_pkg::CORDIC_STAGES;

    logic                           r_v    [N];
    logic signed [glfm_pkg::XW-1:0] r_x    [N];
    logic signed [glfm_pkg::XW-1:0] r_y    [N];
    logic signed [glfm_pkg::ZW-1:0] r_z    [N];
    glfm_pkg::t_side                r_side [N];
    logic                           w_acc  [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic                           w_vin;
            logic signed [glfm_pkg::XW-1:0] w_xin, w_yin;
            logic signed [glfm_pkg::ZW-1:0] w_zin;
            glfm_pkg::t_side                w_sin;
            logic signed [glfm_pkg::ZW-1:0] w_at;

            // Stage inputs
            if (k == 0) begin : g_first
                assign w_vin = i_valid;
                assign w_xin = $signed({{(glfm_pkg::XW - 31){1'b0}}, i_cfg.x0});
                assign w_yin = '0;
                assign w_zin = i_z;
                assign w_sin = i_side;
            end else begin : g_next
                assign w_vin = r_v[k-1];
                assign w_xin = r_x[k-1];
                assign w_yin = r_y[k-1];
                assign w_zin = r_z[k-1];
                assign w_sin = r_side[k-1];
            end

            // Advance chain
            if (k == N - 1) begin : g_last
                assign w_acc[k] = !r_v[k] || i_dn_acc;
            end else begin : g_mid
                assign w_acc[k] = !r_v[k] || w_acc[k+1];
            end

            assign w_at = $signed(glfm_pkg::atan_turn(k[glfm_pkg::STAGE_IDX_W-1:0]));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (w_acc[k]) begin
                    r_v[k] <= w_vin;
                end
            end

            // Micro-rotation toward zero residual angle
            always_ff @(posedge i_clk) begin
                if (w_acc[k]) begin
                    r_side[k] <= w_sin;
                    if (!w_zin[glfm_pkg::ZW-1]) begin
                        r_x[k] <= w_xin - (w_yin >>> k);
                        r_y[k] <= w_yin + (w_xin >>> k);
                        r_z[k] <= w_zin - w_at;
                    end else begin
                        r_x[k] <= w_xin + (w_yin >>> k);
                        r_y[k] <= w_yin - (w_xin >>> k);
                        r_z[k] <= w_zin + w_at;
                    end
                end
            end
        end
    endgenerate

    assign o_acc   = w_acc[0];
    assign o_valid = r_v[N-1];
    assign o_x     = r_x[N-1];
    assign o_y     = r_y[N-1];
    assign o_side  = r_side[N-1];

endmodule

>>> design/glfm_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glfm_out
// Rounding to Q1.15, quadrant unfold, noise add with saturation, gating and
// the output register.
// ----------------------------------------------------------------------------
module glfm_out (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_acc,
    input  logic signed [glfm_pkg::XW-1:0] i_x,
    input  logic signed [glfm_pkg::XW-1:0] i_y,
    input  glfm_pkg::t_side                i_side,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [15:0]             o_re,
    output logic signed [15:0]             o_im,
    output logic signed [glfm_pkg::MW-1:0] o_time,
    output logic                           o_in_window
);

    function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
        logic signed [15:0] r;
        if (v > 22'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -22'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic w_acc1, w_acc2;
    logic r_s1_v, r_s2_v;

    logic signed [18:0]             r_s1_cr, r_s1_ci;
    glfm_pkg::t_side                r_s1_side;
    logic signed [15:0]             r_s2_re, r_s2_im;
    logic signed [glfm_pkg::MW-1:0] r_s2_time;
    logic                           r_s2_inwin;

    logic signed [glfm_pkg::XW-1:0] w_xr, w_yr;
    logic signed [18:0]             w_c, w_s;
    logic signed [18:0]             n_cr, n_ci;
    logic signed [21:0]             w_sum_re, w_sum_im;

    assign w_acc2 = !r_s2_v || !i_stall;
    assign w_acc1 = !r_s1_v || w_acc2;
    assign o_acc  = w_acc1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (w_acc1) r_s1_v <= i_valid;
            if (w_acc2) r_s2_v <= r_s1_v;
        end
    end

    // Round half up to Q1.15, then undo the quadrant fold
    assign w_xr = (i_x + 34'sd32768) >>> 16;
    assign w_yr = (i_y + 34'sd32768) >>> 16;
    assign w_c  = w_xr[18:0];
    assign w_s  = w_yr[18:0];

    always_comb begin
        case (i_side.quad)
            glfm_pkg::QUAD_0: begin
                n_cr = w_c;
                n_ci = w_s;
            end
            glfm_pkg::QUAD_1: begin
                n_cr = -w_s;
                n_ci = w_c;
            end
            glfm_pkg::QUAD_2: begin
                n_cr = -w_c;
                n_ci = -w_s;
            end
            glfm_pkg::QUAD_3: begin
                n_cr = w_s;
                n_ci = -w_c;
            end
            default: begin
                n_cr = w_c;
                n_ci = w_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc1) begin
            r_s1_cr   <= n_cr;
            r_s1_ci   <= n_ci;
            r_s1_side <= i_side;
        end
    end

    // Noise add, saturate, zero outside the window
    assign w_sum_re = 22'(r_s1_cr) + 22'(r_s1_side.nre);
    assign w_sum_im = 22'(r_s1_ci) + 22'(r_s1_side.nim);

    always_ff @(posedge i_clk) begin
        if (w_acc2) begin
            r_s2_re    <= r_s1_side.in_win ? sat16(w_sum_re) : 16'sd0;
            r_s2_im    <= r_s1_side.in_win ? sat16(w_sum_im) : 16'sd0;
            r_s2_time  <= r_s1_side.m;
            r_s2_inwin <= r_s1_side.in_win;
        end
    end

    assign o_valid     = r_s2_v;
    assign o_re        = r_s2_re;
    assign o_im        = r_s2_im;
    assign o_time      = r_s2_time;
    assign o_in_window = r_s2_inwin;

endmodule

>>> design/gated_lfm_chirp_with_noise.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_lfm_chirp_with_noise
// Gated linear-FM chirp source with additive noise, one complex sample per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries a sample index and one noise
//   pair; a transfer happens when valid is high and stall is low. The output
//   channel (o_out_valid / i_out_stall) returns the Q1.15 complex sample, the
//   delayed time and the in-window flag for each input, in order.
//   From input transfer to output valid an item passes 5 phase stages,
//   16 CORDIC stages, 2 output stages. Throughput is one item per cycle while
//   the receiver does not stall; the CORDIC does one rotation per stage.
//   Each stage loads whenever it is empty, so bubbles close up while the
//   receiver stalls; the input stalls only once every stage holds an item.
//   Nothing is lost or repeated across a stall.
//   Synchronous active-low reset empties the pipeline and loads the register
//   defaults (amplitude 16384, window length 1024, the rest zero).
//   Registers are written over the APB port at byte address 4*index and must
//   only change while the pipeline is empty.
// ----------------------------------------------------------------------------
module gated_lfm_chirp_with_noise (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [glfm_pkg::ADDR_W-1:0]   paddr,
    input  logic [glfm_pkg::DATA_W-1:0]   pwdata,
    output logic [glfm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [15:0]                   i_sample_index,
    input  logic signed [15:0]            i_noise_re,
    input  logic signed [15:0]            i_noise_im,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [15:0]            o_out_re,
    output logic signed [15:0]            o_out_im,
    output logic signed [17:0]            o_sample_time,
    output logic                          o_in_window
);

    glfm_pkg::t_cfg                 w_cfg;
    logic                           w_ph_acc;
    logic                           w_ph_valid;
    logic signed [glfm_pkg::ZW-1:0] w_ph_z;
    glfm_pkg::t_side                w_ph_side;
    logic                           w_cd_acc;
    logic                           w_cd_valid;
    logic signed [glfm_pkg::XW-1:0] w_cd_x, w_cd_y;
    glfm_pkg::t_side                w_cd_side;
    logic                           w_out_acc;

    // Configuration registers
    glfm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Gate and phase front end
    glfm_phase u_phase (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (i_in_valid),
        .o_acc          (w_ph_acc),
        .i_sample_index (i_sample_index),
        .i_noise_re     (i_noise_re),
        .i_noise_im     (i_noise_im),
        .o_valid        (w_ph_valid),
        .i_dn_acc       (w_cd_acc),
        .o_z            (w_ph_z),
        .o_side         (w_ph_side)
    );

    assign o_in_stall = !w_ph_acc;

    // Sine/cosine rotation
    glfm_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_ph_valid),
        .o_acc    (w_cd_acc),
        .i_z      (w_ph_z),
        .i_side   (w_ph_side),
        .o_valid  (w_cd_valid),
        .i_dn_acc (w_out_acc),
        .o_x      (w_cd_x),
        .o_y      (w_cd_y),
        .o_side   (w_cd_side)
    );

    // Output formatting and register
    glfm_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_cd_valid),
        .o_acc       (w_out_acc),
        .i_x         (w_cd_x),
        .i_y         (w_cd_y),
        .i_side      (w_cd_side),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_re        (o_out_re),
        .o_im        (o_out_im),
        .o_time      (o_sample_time),
        .o_in_window (o_in_window)
    );

endmodule

>>> tb/sv/gated_lfm_chirp_with_noise_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_lfm_chirp_with_noise_tb
// Self-checking bench for the gated LFM chirp source. A queue-fed driver and a
// clocked monitor exchange samples with the block under random gaps on both
// channels. Every input transfer is turned into an expected complex sample by
// a bit-true chirp/CORDIC/noise predictor, and every output transfer is
// compared with the oldest one. Registers are reloaded over APB between
// batches, with directed edge cases first and random settings after.
// ----------------------------------------------------------------------------
module gated_lfm_chirp_with_noise_tb;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam longint      CORDIC_COMP    = 39797; // 1/K in Q16
    localparam int          RANDOM_BATCHES = 8;
    localparam int          BATCH_ITEMS    = 100;

    // One item offered on the input channel
    typedef struct packed {
        logic        [15:0] index;
        logic signed [15:0] nre;
        logic signed [15:0] nim;
    } t_sample_req;

    // One complex sample as the block should return it
    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic signed [17:0] t;
        logic               win;
    } t_iq_sample;

    // DUT connections, inputs known from time zero
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          psel           = 1'b0;
    logic                          penable        = 1'b0;
    logic                          pwrite         = 1'b0;
    logic [glfm_pkg::ADDR_W-1:0]   paddr          = '0;
    logic [glfm_pkg::DATA_W-1:0]   pwdata         = '0;
    logic [glfm_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic [15:0]                   i_sample_index = '0;
    logic signed [15:0]            i_noise_re     = '0;
    logic signed [15:0]            i_noise_im     = '0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic signed [15:0]            o_out_re;
    logic signed [15:0]            o_out_im;
    logic signed [17:0]            o_sample_time;
    logic                          o_in_window;

    // Mirror of the register file
    logic [31:0]           ps_step  = 32'd0;
    logic [31:0]           chirp_k  = 32'd0;
    logic [15:0]           phi0     = 16'd0;
    logic [14:0]           amp      = 15'd16384;
    logic [14:0]           ngain    = 15'd0;
    logic signed [16:0]    tau      = 17'sd0;
    logic [15:0]           win_len  = 16'd1024;

    // CORDIC rotation angles, 2^32 per turn
    longint cordic_angle [0:15] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    t_sample_req index_backlog [$];
    t_iq_sample  due_samples   [$];
    t_sample_req next_req;
    t_iq_sample  want;

    int unsigned items_queued     = 0;
    int unsigned items_accepted   = 0;
    int unsigned due_checked      = 0;
    int unsigned inside_seen      = 0;
    int unsigned mismatches       = 0;
    int unsigned settings_applied = 0;
    int unsigned quiet_cycles     = 0;
    int          send_gap         = 0;
    int          stall_left       = 0;
    int          hold_left        = 0;
    bit          hold_done        = 1'b0;
    bit          calm             = 1'b0;

    gated_lfm_chirp_with_noise DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_index (i_sample_index),
        .i_noise_re     (i_noise_re),
        .i_noise_im     (i_noise_im),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_re       (o_out_re),
        .o_out_im       (o_out_im),
        .o_sample_time  (o_sample_time),
        .o_in_window    (o_in_window)
    );

    // 125 MHz clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic signed [15:0] sat_q15(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // Expected output for one input transfer under the current registers
    function automatic t_iq_sample chirp_sample(input logic [15:0] n,
                                                input logic signed [15:0] nre,
                                                input logic signed [15:0] nim);
        t_iq_sample      s;
        longint          m, d, q, x, y, z, dx, dy, c, sn, c_rot, s_rot;
        logic [63:0]     lin, bend;
        logic [31:0]     ph, folded;
        glfm_pkg::t_quad quad;
        m     = longint'(n) + longint'(tau);
        s.t   = 18'(m);
        s.win = (m >= 0) && (m <= longint'(win_len));
        s.re  = '0;
        s.im  = '0;
        if (s.win) begin
            // phase accumulator: linear term, chirp term, start phase
            d = 2 * m - longint'(win_len);
            if (d < 0)
                d = -d;
            q    = d * d;
            lin  = 64'(ps_step) * 64'(m);
            bend = 64'(chirp_k) * 64'(q);
            ph   = lin[31:0] + bend[39:8] + {phi0, 16'h0000};
            ph   = ph & ~((32'd1 << (32 - glfm_pkg::PHASE_BITS)) - 32'd1);

            // fold into +-1/8 turn, then rotate
            folded = ph + 32'h2000_0000;
            quad   = glfm_pkg::t_quad'(folded[31:30]);
            z      = longint'($signed(ph - {folded[31:30], 30'b0}));
            x      = longint'(amp) * CORDIC_COMP;
            y      = 0;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - cordic_angle[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + cordic_angle[i];
                end
            end
            c  = (x + 32768) >>> 16;
            sn = (y + 32768) >>> 16;
            case (quad)
                glfm_pkg::QUAD_0: begin c_rot = c;   s_rot = sn;  end
                glfm_pkg::QUAD_1: begin c_rot = -sn; s_rot = c;   end
                glfm_pkg::QUAD_2: begin c_rot = -c;  s_rot = -sn; end
                default: begin c_rot = sn; s_rot = -c;  end
            endcase

            // add scaled noise (round half up) and saturate
            s.re = sat_q15(c_rot + ((longint'(ngain) * longint'(nre) + 1024) >>> 11));
            s.im = sat_q15(s_rot + ((longint'(ngain) * longint'(nim) + 1024) >>> 11));
        end
        return s;
    endfunction

    // Mostly short gaps, a few long ones, none while calm
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 16);
        return $urandom_range(30, 80);
    endfunction

    // Extreme low, extreme high, or anything in between
    function automatic longint pick_value(input longint lo, input longint hi);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            default: return lo + longint'($urandom_range(0, 32'(hi - lo)));
        endcase
    endfunction

    // Noise: mostly within +-4096, sometimes any 16-bit value
    function automatic logic [15:0] noise_draw();
        if ($urandom_range(0, 9) < 7)
            return 16'(int'($urandom_range(0, 8192)) - 4096);
        return 16'($urandom);
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
        mismatches++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    endtask

    // APB write: setup, access, then release
    task automatic set_reg(input glfm_pkg::t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            glfm_pkg::REG_PHASE_STEP:  ps_step = val;
            glfm_pkg::REG_CHIRP_COEF:  chirp_k = val;
            glfm_pkg::REG_START_PHASE: phi0    = val[15:0];
            glfm_pkg::REG_AMPLITUDE:   amp     = val[14:0];
            glfm_pkg::REG_NOISE_GAIN:  ngain   = val[14:0];
            glfm_pkg::REG_DELAY:       tau     = val[16:0];
            glfm_pkg::REG_WINDOW_LEN:  win_len = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] ps, input logic [31:0] ck,
                                 input logic [15:0] ph, input logic [14:0] a,
                                 input logic [14:0] g, input int dl,
                                 input logic [15:0] wl);
        set_reg(glfm_pkg::REG_PHASE_STEP, ps);
        set_reg(glfm_pkg::REG_CHIRP_COEF, ck);
        set_reg(glfm_pkg::REG_START_PHASE, {16'h0000, ph});
        set_reg(glfm_pkg::REG_AMPLITUDE, {17'h0, a});
        set_reg(glfm_pkg::REG_NOISE_GAIN, {17'h0, g});
        set_reg(glfm_pkg::REG_DELAY, 32'(dl));
        set_reg(glfm_pkg::REG_WINDOW_LEN, {16'h0000, wl});
        settings_applied++;
    endtask

    task automatic queue_item(input logic [15:0] n, input logic [15:0] nre,
                              input logic [15:0] nim);
        t_sample_req r;
        r.index = n;
        r.nre   = nre;
        r.nim   = nim;
        index_backlog.push_back(r);
        items_queued++;
    endtask

    // Most indexes land on or near the pulse window, the rest anywhere
    task automatic queue_random(input int count);
        int     target;
        longint n;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                target = int'($urandom_range(0, 32'(win_len) + 8)) - 4;
                n      = longint'(target) - longint'(tau);
                if (n < 0 || n > 65535)
                    n = $urandom_range(0, 65535);
            end else begin
                n = $urandom_range(0, 65535);
            end
            queue_item(16'(n), noise_draw(), noise_draw());
        end
    endtask

    // Everything queued has been sent and every result has come back
    task automatic wait_drained();
        while (!(items_accepted == items_queued && due_checked == items_queued))
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Input driver: one item per transfer, random gaps between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap    = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                due_samples.push_back(chirp_sample(i_sample_index, i_noise_re, i_noise_im));
                items_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (index_backlog.size() > 0) begin
                    next_req        = index_backlog.pop_front();
                    i_sample_index <= next_req.index;
                    i_noise_re     <= next_req.nre;
                    i_noise_im     <= next_req.nim;
                    i_in_valid     <= 1'b1;
                    send_gap        = gap_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each transfer, drive the stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left   = 0;
            hold_left    = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_samples.size() == 0) begin
                    flag_mismatch("sample with nothing due, sample_time", o_sample_time, 0);
                end else begin
                    want = due_samples.pop_front();
                    if (o_out_re !== want.re)
                        flag_mismatch("out_re", o_out_re, want.re);
                    if (o_out_im !== want.im)
                        flag_mismatch("out_im", o_out_im, want.im);
                    if (o_sample_time !== want.t)
                        flag_mismatch("sample_time", o_sample_time, want.t);
                    if (o_in_window !== want.win)
                        flag_mismatch("in_window", o_in_window, want.win);
                    if (want.win)
                        inside_seen++;
                    due_checked++;
                end
            end

            // one long hold-off while the sender still has plenty to offer
            if (!hold_done && due_checked >= 280 && index_backlog.size() > 10) begin
                hold_left = 250;
                hold_done = 1'b1;
            end

            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left   = gap_len();
            end
        end
    end

    // Watchdog: too long without a transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles, %0d samples outstanding", $realtime,
                     quiet_cycles, due_samples.size());
            $display("gated_lfm_chirp_with_noise_tb failed");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: window edges, far outside with noise ignored
        settings_applied = 1;
        queue_item(16'd0, 16'h0000, 16'h0000);
        queue_item(16'd1024, 16'h0800, 16'hF800);
        queue_item(16'd1025, 16'h7FFF, 16'h8000);
        queue_item(16'd65535, 16'h8000, 16'h7FFF);
        wait_drained();

        // eighth-turn steps: every quadrant and fold boundary, full amplitude
        load_settings(32'h2000_0000, 32'd0, 16'h0000, 15'h7FFF, 15'd0, 0, 16'd1024);
        for (int k = 0; k < 8; k++)
            queue_item(16'(k), 16'h0000, 16'h0000);
        wait_drained();

        // delay of -65535, widest window, zero amplitude, noise saturation
        load_settings(32'h0123_4567, 32'hFFFF_FFFF, 16'hFFFF, 15'd0, 15'h7FFF, -65535,
                      16'hFFFF);
        queue_item(16'd65535, 16'h7FFF, 16'h8000);
        queue_item(16'd65534, 16'h7FFF, 16'h8000);
        queue_item(16'd0, 16'h5555, 16'hAAAA);
        wait_drained();

        // most positive delay: largest delayed time
        load_settings(32'd0, 32'h0000_0100, 16'h8000, 15'd16384, 15'h7FFF, 65535, 16'hFFFF);
        queue_item(16'd0, 16'h5555, 16'hAAAA);
        queue_item(16'd1, 16'hAAAA, 16'h5555);
        queue_item(16'd65535, 16'h0000, 16'h0000);
        wait_drained();

        // zero window length: only m = 0 is inside
        load_settings(32'h1000_0000, 32'h0000_0001, 16'h1234, 15'd20000, 15'd1000, 0, 16'd0);
        queue_item(16'd0, 16'h0400, 16'hFC00);
        queue_item(16'd1, 16'h0400, 16'hFC00);
        wait_drained();

        // random settings, random items, some batches without idling
        for (int p = 0; p < RANDOM_BATCHES; p++) begin
            calm = (p % 3 == 2);
            load_settings(32'(pick_value(0, 32'hFFFF_FFFF)),
                          32'(pick_value(0, 32'hFFFF_FFFF)),
                          16'(pick_value(0, 65535)),
                          15'(pick_value(0, 32767)),
                          15'(pick_value(0, 32767)),
                          int'(pick_value(-65535, 65535)),
                          16'(pick_value(1, 65535)));
            queue_random(BATCH_ITEMS);
            wait_drained();
        end
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_samples.size() != 0)
            flag_mismatch("samples never returned", due_samples.size(), 0);

        $display("run covered %0d samples, %0d inside the pulse window, under %0d settings",
                 items_queued, inside_seen, settings_applied);
        $display("long receiver hold-off exercised: %0d, mismatches: %0d", hold_done,
                 mismatches);
        if (mismatches == 0) begin
            $display("gated_lfm_chirp_with_noise_tb passed");
        end else begin
            $display("gated_lfm_chirp_with_noise_tb failed");
        end
        $finish;
    end

endmodule
